FILE: rtl/core/brcd_pkg.sv
// ----------------------------------------------------------------------------
// brcd_pkg
// Shared types and constants for the byte run-length channel decoder.
// ----------------------------------------------------------------------------
package brcd_pkg;

  localparam int unsigned BYTES_PER_RESULT = 4;
  localparam int unsigned LANES            = 4;
  localparam int unsigned MAX_RESULTS      = 32;
  localparam int unsigned RES_SHIFT        = $clog2(MAX_RESULTS);
  localparam int unsigned PACK_BASE        = (BYTES_PER_RESULT < 1) ? 1 :
                                             (BYTES_PER_RESULT > LANES) ? LANES :
                                             BYTES_PER_RESULT;
  localparam logic [7:0]  RUN_BASE         = 8'd128;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_LITERAL = 2'd1,
    MODE_RUN     = 2'd2
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_run;
    logic run_emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_pending;
    logic run_empty;
    logic run_last;
  } sts_t;

endpackage

FILE: rtl/core/brcd_ctrl.sv
// ----------------------------------------------------------------------------
// brcd_ctrl
// Sequencer: takes bytes, and holds input while a run drains.
// ----------------------------------------------------------------------------
module brcd_ctrl import brcd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = !sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && sts.run_pending && !sts.run_empty) begin
          cmd.start_run = 1'b1;
          state_next    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.run_emit = 1'b1;
          if (sts.run_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/brcd_dp.sv
// ----------------------------------------------------------------------------
// brcd_dp
// Decode state, run expander and output register.
// ----------------------------------------------------------------------------
module brcd_dp import brcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  logic        in_final,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_data,
  output logic [2:0]  out_bytes,
  output logic        item_end,
  output logic        stream_done,
  output logic        status
);

  mode_t       mode;
  logic [7:0]  literal_left;
  logic [6:0]  repeat_count;

  logic [7:0]  run_byte;
  logic [6:0]  run_left;
  logic [2:0]  run_pack;
  logic        run_fin;

  logic [7:0]  need_sum;
  logic [2:0]  need;
  logic [2:0]  pack_new;
  logic [2:0]  run_n;
  logic [31:0] run_data;
  logic [7:0]  lit_dec;

  assign need_sum = {1'b0, repeat_count} + 8'(MAX_RESULTS - 1);
  assign need     = 3'(need_sum >> RES_SHIFT);
  assign pack_new = (need > 3'(PACK_BASE)) ? ((need > 3'(LANES)) ? 3'(LANES) : need)
                                           : 3'(PACK_BASE);

  assign run_n = ({4'd0, run_pack} < run_left) ? run_pack : run_left[2:0];
  assign lit_dec = literal_left - 8'd1;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      run_data[8*i +: 8] = (3'(i) < run_n) ? run_byte : 8'd0;
    end
  end

  assign sts.out_free    = !out_valid || !out_stall;
  assign sts.run_pending = (mode == MODE_RUN);
  assign sts.run_empty   = (repeat_count == 7'd0);
  assign sts.run_last    = (run_left <= {4'd0, run_pack});

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_HEADER;
      literal_left <= 8'd0;
      repeat_count <= 7'd0;
    end else if (cmd.accept) begin
      if (in_final) begin
        mode         <= MODE_HEADER;
        literal_left <= 8'd0;
        repeat_count <= 7'd0;
      end else begin
        unique case (mode)
          MODE_RUN: begin
            mode         <= MODE_HEADER;
            repeat_count <= 7'd0;
          end
          MODE_LITERAL: begin
            literal_left <= lit_dec;
            if (lit_dec == 8'd0) begin
              mode <= MODE_HEADER;
            end
          end
          default: begin
            if (in_byte > RUN_BASE) begin
              repeat_count <= 7'(in_byte - RUN_BASE);
              mode         <= MODE_RUN;
            end else if (in_byte != 8'd0) begin
              literal_left <= in_byte;
              mode         <= MODE_LITERAL;
            end else begin
              mode <= MODE_HEADER;
            end
          end
        endcase
      end
    end
  end

  // run registers
  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      run_byte <= in_byte;
      run_left <= repeat_count;
      run_pack <= pack_new;
      run_fin  <= in_final;
    end else if (cmd.run_emit) begin
      run_left <= run_left - {4'd0, run_n};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.accept && !cmd.start_run) || cmd.run_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_emit) begin
      out_data    <= run_data;
      out_bytes   <= run_n;
      item_end    <= sts.run_last;
      stream_done <= sts.run_last && run_fin;
      status      <= 1'b0;
    end else if (cmd.accept && !cmd.start_run) begin
      item_end    <= 1'b1;
      stream_done <= in_final;
      unique case (mode)
        MODE_RUN: begin
          out_data  <= 32'd0;
          out_bytes <= 3'd0;
          status    <= 1'b0;
        end
        MODE_LITERAL: begin
          out_data  <= {24'd0, in_byte};
          out_bytes <= 3'd1;
          status    <= in_final && (lit_dec != 8'd0);
        end
        default: begin
          out_data  <= 32'd0;
          out_bytes <= 3'd0;
          status    <= in_final && (in_byte != 8'd0);
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/byte_rle_channel_decoder.sv
// ----------------------------------------------------------------------------
// byte_rle_channel_decoder
// Expands a byte run-length coded channel, packing decoded bytes per result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall   | in_byte, in_final
//  out     | out of    | out_valid/out_stall | out_data, out_bytes, item_end,
//          |           |                     | stream_done, status
//
//  Header and literal bytes are taken back to back while the output is free.
//  A run byte expands into ceil(count / pack) results: the single output
//  register issues one packed result per cycle, unless the output is stalled, while input is held.
//  rst is synchronous; it returns the decoder to expecting a header byte.
//  A stalled output holds the result; input is held until it is taken.
// ----------------------------------------------------------------------------
module byte_rle_channel_decoder import brcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_data,
  output logic [2:0]  out_bytes,
  output logic        item_end,
  output logic        stream_done,
  output logic        status
);

  cmd_t cmd;
  sts_t sts;

  brcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  brcd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (in_byte),
    .in_final    (in_final),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .out_bytes   (out_bytes),
    .item_end    (item_end),
    .stream_done (stream_done),
    .status      (status)
  );

endmodule
